// ----- sv/triangle_overlap_test_2d_macros.svh -----
// ----------------------------------------------------------------------------
// Triangle overlap test assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_OVERLAP_TEST_2D_MACROS_SVH
`define TRIANGLE_OVERLAP_TEST_2D_MACROS_SVH
`ifndef SYNTHESIS
`define TOL_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define TOL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define TOL_ASSERT(label, expr, msg)
`define TOL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- sv/tol_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle overlap test package
// Widths, point and triple codes, and orientation lookup helpers.
// ----------------------------------------------------------------------------
package tol_pkg;

   localparam int COORD_BITS = 24;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int DET_BITS   = PROD_BITS + 1;
   localparam int NUM_PTS    = 6;
   localparam int NUM_TRI    = 20;
   localparam int PT_BITS    = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [PT_BITS-1:0] pt_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

   typedef sign_type [NUM_TRI-1:0] sign_vec_type;

   typedef struct packed {
      logic diff;
      logic mult;
      logic sign;
   } stage_en_type;

   localparam pt_type PT_P1 = 3'd0;
   localparam pt_type PT_Q1 = 3'd1;
   localparam pt_type PT_R1 = 3'd2;
   localparam pt_type PT_P2 = 3'd3;
   localparam pt_type PT_Q2 = 3'd4;
   localparam pt_type PT_R2 = 3'd5;

   localparam pt_type TRI_A [NUM_TRI] = '{
      PT_P1, PT_P1, PT_P1, PT_P1, PT_P1, PT_P1, PT_P1, PT_P1, PT_P1, PT_P1,
      PT_Q1, PT_Q1, PT_Q1, PT_Q1, PT_Q1, PT_Q1, PT_R1, PT_R1, PT_R1, PT_P2};
   localparam pt_type TRI_B [NUM_TRI] = '{
      PT_Q1, PT_Q1, PT_Q1, PT_Q1, PT_R1, PT_R1, PT_R1, PT_P2, PT_P2, PT_Q2,
      PT_R1, PT_R1, PT_R1, PT_P2, PT_P2, PT_Q2, PT_P2, PT_P2, PT_Q2, PT_Q2};
   localparam pt_type TRI_C [NUM_TRI] = '{
      PT_R1, PT_P2, PT_Q2, PT_R2, PT_P2, PT_Q2, PT_R2, PT_Q2, PT_R2, PT_R2,
      PT_P2, PT_Q2, PT_R2, PT_Q2, PT_R2, PT_R2, PT_Q2, PT_R2, PT_R2, PT_R2};

   function automatic sign_type orient_of(input sign_vec_type s, input pt_type a,
                                          input pt_type b, input pt_type c);
      pt_type   x;
      pt_type   y;
      pt_type   z;
      pt_type   t;
      logic     odd;
      sign_type r;
      sign_type res;
      x   = a;
      y   = b;
      z   = c;
      odd = 1'b0;
      r   = '0;
      if (x > y) begin
         t = x; x = y; y = t; odd = !odd;
      end
      if (y > z) begin
         t = y; y = z; z = t; odd = !odd;
      end
      if (x > y) begin
         t = x; x = y; y = t; odd = !odd;
      end
      for (int i = 0; i < NUM_TRI; i++) begin
         if (TRI_A[i] == x && TRI_B[i] == y && TRI_C[i] == z) begin
            r = s[i];
         end
      end
      res.zero = r.zero;
      res.neg  = r.neg ^ (odd & !r.zero);
      return res;
   endfunction

   function automatic logic or_ge(input sign_vec_type s, input pt_type a,
                                  input pt_type b, input pt_type c);
      sign_type r;
      r = orient_of(s, a, b, c);
      return !r.neg;
   endfunction

   function automatic logic or_le(input sign_vec_type s, input pt_type a,
                                  input pt_type b, input pt_type c);
      sign_type r;
      r = orient_of(s, a, b, c);
      return r.neg | r.zero;
   endfunction

   function automatic logic or_gt(input sign_vec_type s, input pt_type a,
                                  input pt_type b, input pt_type c);
      sign_type r;
      r = orient_of(s, a, b, c);
      return !r.neg & !r.zero;
   endfunction

   function automatic logic or_lt(input sign_vec_type s, input pt_type a,
                                  input pt_type b, input pt_type c);
      sign_type r;
      r = orient_of(s, a, b, c);
      return r.neg;
   endfunction

endpackage

// ----- sv/tol_orient.sv -----
// ----------------------------------------------------------------------------
// Triangle overlap orientation lane
// Three-stage exact sign of (a-c) x (b-c): differences, products, subtract.
// ----------------------------------------------------------------------------
module tol_orient import tol_pkg::*; (
   input  logic         clock,
   input  stage_en_type en,
   input  point_type    pt_a,
   input  point_type    pt_b,
   input  point_type    pt_c,
   output sign_type     sign
);

   logic signed [DIFF_BITS-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic signed [DIFF_BITS-1:0] dx1_in, dy1_in, dx2_in, dy2_in;
   logic signed [PROD_BITS-1:0] prod_p_ff, prod_q_ff, prod_p_in, prod_q_in;
   logic signed [DET_BITS-1:0]  det;
   sign_type                    sign_ff, sign_in;

   always_comb begin
      dx1_in    = DIFF_BITS'(pt_a.x) - DIFF_BITS'(pt_c.x);
      dy1_in    = DIFF_BITS'(pt_a.y) - DIFF_BITS'(pt_c.y);
      dx2_in    = DIFF_BITS'(pt_b.x) - DIFF_BITS'(pt_c.x);
      dy2_in    = DIFF_BITS'(pt_b.y) - DIFF_BITS'(pt_c.y);
      prod_p_in = PROD_BITS'(dx1_ff) * PROD_BITS'(dy2_ff);
      prod_q_in = PROD_BITS'(dy1_ff) * PROD_BITS'(dx2_ff);
      det       = DET_BITS'(prod_p_ff) - DET_BITS'(prod_q_ff);
      sign_in.neg  = det[DET_BITS-1];
      sign_in.zero = (det == '0);
   end

   always_ff @(posedge clock) begin
      if (en.diff) begin
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
         dx2_ff <= dx2_in;
         dy2_ff <= dy2_in;
      end
      if (en.mult) begin
         prod_p_ff <= prod_p_in;
         prod_q_ff <= prod_q_in;
      end
      if (en.sign) begin
         sign_ff <= sign_in;
      end
   end

   assign sign = sign_ff;

endmodule

// ----- sv/tol_decide.sv -----
// ----------------------------------------------------------------------------
// Triangle overlap decision tree
// Walks the vertex and edge sub-tests over the registered orientation signs.
// ----------------------------------------------------------------------------
module tol_decide import tol_pkg::*; (
   input  sign_vec_type signs,
   output logic         hit,
   output logic         enclosed
);

   function automatic logic test_vertex(input sign_vec_type s,
                                        input pt_type p1, input pt_type q1,
                                        input pt_type r1, input pt_type p2,
                                        input pt_type q2, input pt_type r2);
      logic res;
      if (or_ge(s, r2, p2, q1)) begin
         if (or_le(s, r2, q2, q1)) begin
            if (or_gt(s, p1, p2, q1))
               res = or_le(s, p1, q2, q1);
            else if (or_lt(s, p1, p2, r1))
               res = 1'b0;
            else
               res = or_ge(s, q1, r1, p2);
         end else if (or_gt(s, p1, q2, q1))
            res = 1'b0;
         else if (or_gt(s, r2, q2, r1))
            res = 1'b0;
         else
            res = or_ge(s, q1, r1, q2);
      end else if (or_lt(s, r2, p2, r1))
         res = 1'b0;
      else if (or_ge(s, q1, r1, r2))
         res = or_ge(s, p1, p2, r1);
      else if (or_lt(s, q1, r1, q2))
         res = 1'b0;
      else
         res = or_ge(s, r2, r1, q2);
      return res;
   endfunction

   function automatic logic test_edge(input sign_vec_type s,
                                      input pt_type p1, input pt_type q1,
                                      input pt_type r1, input pt_type p2,
                                      input pt_type r2);
      logic res;
      if (or_ge(s, r2, p2, q1)) begin
         if (or_ge(s, p1, p2, q1))
            res = or_ge(s, p1, q1, r2);
         else if (or_lt(s, q1, r1, p2))
            res = 1'b0;
         else
            res = or_ge(s, r1, p1, p2);
      end else if (or_lt(s, r2, p2, r1))
         res = 1'b0;
      else if (or_lt(s, p1, p2, r1))
         res = 1'b0;
      else if (or_ge(s, p1, r1, r2))
         res = 1'b1;
      else
         res = or_ge(s, q1, r1, r2);
      return res;
   endfunction

   always_comb begin
      enclosed = 1'b0;
      if (or_ge(signs, PT_P2, PT_Q2, PT_P1)) begin
         if (or_ge(signs, PT_Q2, PT_R2, PT_P1)) begin
            if (or_ge(signs, PT_R2, PT_P2, PT_P1)) begin
               enclosed = 1'b1;
               hit      = 1'b1;
            end else
               hit = test_edge(signs, PT_P1, PT_Q1, PT_R1, PT_P2, PT_R2);
         end else if (or_ge(signs, PT_R2, PT_P2, PT_P1))
            hit = test_edge(signs, PT_P1, PT_Q1, PT_R1, PT_R2, PT_Q2);
         else
            hit = test_vertex(signs, PT_P1, PT_Q1, PT_R1, PT_P2, PT_Q2, PT_R2);
      end else if (or_ge(signs, PT_Q2, PT_R2, PT_P1)) begin
         if (or_ge(signs, PT_R2, PT_P2, PT_P1))
            hit = test_edge(signs, PT_P1, PT_Q1, PT_R1, PT_Q2, PT_P2);
         else
            hit = test_vertex(signs, PT_P1, PT_Q1, PT_R1, PT_Q2, PT_R2, PT_P2);
      end else
         hit = test_vertex(signs, PT_P1, PT_Q1, PT_R1, PT_R2, PT_P2, PT_Q2);
   end

endmodule

// ----- sv/triangle_overlap_test_2d.sv -----
// ----------------------------------------------------------------------------
// Triangle overlap test, 2D
// Five-stage pipeline: capture, differences, products, signs, decision.
//
//   channel  ports            direction  beat
//   req      req_tri*_*       in         one triangle pair
//   rsp      rsp_overlap/...  out        overlap and first-vertex flags
//
// One request a cycle while rsp_stall does not hold the pipe; the response
// is valid once the request has passed all five register stages.
// Twenty lanes each own two 25x25 multipliers.
// Reset clears the stage valid bits only; no clearing pass.
// Each stage loads when empty or when the next stage moves, so bubbles close
// up under rsp_stall.
// ----------------------------------------------------------------------------
`include "triangle_overlap_test_2d_macros.svh"
module triangle_overlap_test_2d import tol_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  coord_type req_tri1_ax,
   input  coord_type req_tri1_ay,
   input  coord_type req_tri1_bx,
   input  coord_type req_tri1_by,
   input  coord_type req_tri1_cx,
   input  coord_type req_tri1_cy,
   input  coord_type req_tri2_ax,
   input  coord_type req_tri2_ay,
   input  coord_type req_tri2_bx,
   input  coord_type req_tri2_by,
   input  coord_type req_tri2_cx,
   input  coord_type req_tri2_cy,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output logic      rsp_overlap,
   output logic      rsp_first_vertex_inside
);

   logic         v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic         v0_in, v1_in, v2_in, v3_in, v4_in;
   logic         en0, en1, en2, en3, en4;
   stage_en_type lane_en;
   point_type    pts_ff [NUM_PTS];
   point_type    pts_in [NUM_PTS];
   sign_vec_type signs;
   logic         hit, enclosed;
   logic         overlap_ff, inside_ff;

   always_comb begin
      en4 = !v4_ff || !rsp_stall;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
      en0 = !v0_ff || en1;
      v0_in = en0 ? req_valid : v0_ff;
      v1_in = en1 ? v0_ff : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
      lane_en.diff = en1;
      lane_en.mult = en2;
      lane_en.sign = en3;
      pts_in[PT_P1] = '{x: req_tri1_ax, y: req_tri1_ay};
      pts_in[PT_Q1] = '{x: req_tri1_bx, y: req_tri1_by};
      pts_in[PT_R1] = '{x: req_tri1_cx, y: req_tri1_cy};
      pts_in[PT_P2] = '{x: req_tri2_ax, y: req_tri2_ay};
      pts_in[PT_Q2] = '{x: req_tri2_bx, y: req_tri2_by};
      pts_in[PT_R2] = '{x: req_tri2_cx, y: req_tri2_cy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         pts_ff <= pts_in;
      end
      if (en4) begin
         overlap_ff <= hit;
         inside_ff  <= enclosed;
      end
   end

   for (genvar g = 0; g < NUM_TRI; g++) begin : g_lane
      tol_orient u_orient (
         .clock (clock),
         .en    (lane_en),
         .pt_a  (pts_ff[TRI_A[g]]),
         .pt_b  (pts_ff[TRI_B[g]]),
         .pt_c  (pts_ff[TRI_C[g]]),
         .sign  (signs[g])
      );
   end

   tol_decide u_decide (
      .signs    (signs),
      .hit      (hit),
      .enclosed (enclosed)
   );

   assign req_stall               = !en0;
   assign rsp_valid               = v4_ff;
   assign rsp_overlap             = overlap_ff;
   assign rsp_first_vertex_inside = inside_ff;

   `TOL_ASSERT(a_inside_implies_overlap, !v4_ff || !inside_ff || overlap_ff, "inside without overlap")
   `TOL_ASSERT(a_stall_only_when_full, en0 || (v0_ff && v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall), "stall with room in pipe")
   `TOL_ASSERT_NEXT(a_held_stage_keeps_valid, v2_ff && !en3, v2_ff, "held request dropped")

endmodule

// ----- tb/sv/tb_triangle_overlap_test_2d.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle overlap test bench
// Drives triangle pairs through the valid/stall request channel, predicts the
// overlap and first-vertex flags from exact orientation signs, and compares
// every response in order. Directed corners, then random pairs under random
// gaps and stalls, with one long response hold-off and two drain pauses.
// ----------------------------------------------------------------------------
module tb_triangle_overlap_test_2d;
   import tol_pkg::*;

   typedef struct {
      logic signed [63:0] x;
      logic signed [63:0] y;
   } vtx_type;

   typedef struct packed {
      logic overlap;
      logic enclosed;
   } flags_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   coord_type req_tri1_ax, req_tri1_ay, req_tri1_bx, req_tri1_by;
   coord_type req_tri1_cx, req_tri1_cy, req_tri2_ax, req_tri2_ay;
   coord_type req_tri2_bx, req_tri2_by, req_tri2_cx, req_tri2_cy;
   logic      rsp_valid;
   logic      rsp_stall;
   logic      rsp_overlap;
   logic      rsp_first_vertex_inside;

   flags_type expected_flags[$];
   int        mismatches;
   int        hold_cycles;
   int        rsp_wait;
   bit        random_stall_on;

   triangle_overlap_test_2d dut (.*);

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int orient(vtx_type a, vtx_type b, vtx_type c);
      logic signed [127:0] d;
      d = 128'(a.x - c.x) * 128'(b.y - c.y) - 128'(a.y - c.y) * 128'(b.x - c.x);
      return (d < 0) ? -1 : ((d == 0) ? 0 : 1);
   endfunction

   function automatic bit vertex_hit(vtx_type p1, vtx_type q1, vtx_type r1,
                                     vtx_type p2, vtx_type q2, vtx_type r2);
      if (orient(r2, p2, q1) >= 0) begin
         if (orient(r2, q2, q1) <= 0) begin
            if (orient(p1, p2, q1) > 0) return orient(p1, q2, q1) <= 0;
            if (orient(p1, p2, r1) < 0) return 0;
            return orient(q1, r1, p2) >= 0;
         end
         if (orient(p1, q2, q1) > 0) return 0;
         if (orient(r2, q2, r1) > 0) return 0;
         return orient(q1, r1, q2) >= 0;
      end
      if (orient(r2, p2, r1) < 0) return 0;
      if (orient(q1, r1, r2) >= 0) return orient(p1, p2, r1) >= 0;
      if (orient(q1, r1, q2) < 0) return 0;
      return orient(r2, r1, q2) >= 0;
   endfunction

   function automatic bit edge_hit(vtx_type p1, vtx_type q1, vtx_type r1,
                                   vtx_type p2, vtx_type r2);
      if (orient(r2, p2, q1) >= 0) begin
         if (orient(p1, p2, q1) >= 0) return orient(p1, q1, r2) >= 0;
         if (orient(q1, r1, p2) < 0) return 0;
         return orient(r1, p1, p2) >= 0;
      end
      if (orient(r2, p2, r1) < 0) return 0;
      if (orient(p1, p2, r1) < 0) return 0;
      if (orient(p1, r1, r2) >= 0) return 1;
      return orient(q1, r1, r2) >= 0;
   endfunction

   function automatic flags_type predict_overlap(coord_type c[12]);
      vtx_type   v[6];
      flags_type f;
      for (int i = 0; i < 6; i++) begin
         v[i].x = c[2*i];
         v[i].y = c[2*i+1];
      end
      f.enclosed = 1'b0;
      if (orient(v[3], v[4], v[0]) >= 0) begin
         if (orient(v[4], v[5], v[0]) >= 0) begin
            if (orient(v[5], v[3], v[0]) >= 0) begin
               f.enclosed = 1'b1;
               f.overlap  = 1'b1;
            end else
               f.overlap = edge_hit(v[0], v[1], v[2], v[3], v[5]);
         end else if (orient(v[5], v[3], v[0]) >= 0)
            f.overlap = edge_hit(v[0], v[1], v[2], v[5], v[4]);
         else
            f.overlap = vertex_hit(v[0], v[1], v[2], v[3], v[4], v[5]);
      end else if (orient(v[4], v[5], v[0]) >= 0) begin
         if (orient(v[5], v[3], v[0]) >= 0)
            f.overlap = edge_hit(v[0], v[1], v[2], v[4], v[3]);
         else
            f.overlap = vertex_hit(v[0], v[1], v[2], v[4], v[5], v[3]);
      end else
         f.overlap = vertex_hit(v[0], v[1], v[2], v[5], v[3], v[4]);
      return f;
   endfunction

   task automatic send_pair(coord_type c[12], bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 8) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_tri1_ax <= c[0];  req_tri1_ay <= c[1];
      req_tri1_bx <= c[2];  req_tri1_by <= c[3];
      req_tri1_cx <= c[4];  req_tri1_cy <= c[5];
      req_tri2_ax <= c[6];  req_tri2_ay <= c[7];
      req_tri2_bx <= c[8];  req_tri2_by <= c[9];
      req_tri2_cx <= c[10]; req_tri2_cy <= c[11];
      expected_flags = {expected_flags, predict_overlap(c)};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   function automatic coord_type rand_coord(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic bit predict_orient_cw(coord_type ax, ay, bx, by, cx, cy);
      vtx_type a, b, c;
      a.x = ax; a.y = ay; b.x = bx; b.y = by; c.x = cx; c.y = cy;
      return orient(a, b, c) < 0;
   endfunction

   task automatic test_corners();
      coord_type c[12];
      coord_type mx, mn;
      mx = {1'b0, {(COORD_BITS-1){1'b1}}};
      mn = {1'b1, {(COORD_BITS-1){1'b0}}};
      // extremes, degenerate and touching cases
      foreach (c[i]) c[i] = mx;
      send_pair(c);
      foreach (c[i]) c[i] = mn;
      send_pair(c);
      foreach (c[i]) c[i] = 0;
      send_pair(c);
      c = '{mn, mn, mx, mn, mx, mx, mn, mn, mx, mn, mx, mx};
      send_pair(c);
      c = '{mx, mx, mn, mx, mn, mn, mn, mn, mx, mn, mx, mx};
      send_pair(c);
      c = '{mn, mx, mn, mn, mx, mn, mx, mx, mn, mx, mn, mn};
      send_pair(c);
      c = '{0, 0, 10, 0, 0, 10, 10, 0, 20, 0, 10, 10};
      send_pair(c);
      c = '{1, 1, 2, 1, 1, 2, 0, 0, 10, 0, 0, 10};
      send_pair(c);
      c = '{100, 100, 110, 100, 100, 110, 0, 0, 10, 0, 0, 10};
      send_pair(c);
      c = '{-5, 5, 15, -5, 15, 15, 0, 0, 10, 0, 0, 10};
      send_pair(c);
      c = '{0, 0, 10, 10, 20, 20, 0, 0, 10, 0, 0, 10};
      send_pair(c);
      c = '{0, 0, 0, 10, 10, 0, 0, 0, 10, 0, 0, 10};
      send_pair(c);
      c = '{20, 20, 30, 20, 20, 30, 0, 0, 10, 0, 0, 10};
      send_pair(c);
      c = '{-10, 4, -1, 4, -5, 20, 0, 0, 10, 0, 0, 10};
      send_pair(c);
      c = '{4, -10, 20, 4, 4, -1, 0, 0, 10, 0, 0, 10};
      send_pair(c);
      c = '{mx, 0, mx, mx, 0, mx, 0, 0, mn, 0, 0, mn};
      send_pair(c);
   endtask

   task automatic test_random(int count);
      coord_type c[12];
      int span, k;
      for (int n = 0; n < count; n++) begin
         k    = $urandom_range(0, 9);
         span = (k < 2) ? 0 : (k < 5) ? 16 : (k < 8) ? 1000 : 4000000;
         foreach (c[i]) c[i] = rand_coord(span);
         if (k < 8 && $urandom_range(0, 1)) begin
            // orient both triangles counterclockwise
            if (predict_orient_cw(c[0], c[1], c[2], c[3], c[4], c[5])) begin
               c[2] = c[2] ^ c[4]; c[4] = c[2] ^ c[4]; c[2] = c[2] ^ c[4];
               c[3] = c[3] ^ c[5]; c[5] = c[3] ^ c[5]; c[3] = c[3] ^ c[5];
            end
            if (predict_orient_cw(c[6], c[7], c[8], c[9], c[10], c[11])) begin
               c[8] = c[8] ^ c[10]; c[10] = c[8] ^ c[10]; c[8] = c[8] ^ c[10];
               c[9] = c[9] ^ c[11]; c[11] = c[9] ^ c[11]; c[9] = c[9] ^ c[11];
            end
         end
         send_pair(c, n % 60 < 40);
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 60;
      test_random(30);
      stop_sending();
      wait (hold_cycles == 0 && expected_flags.size() == 0);
      @(posedge clock);
   endtask

   task automatic drain_pause();
      stop_sending();
      wait (expected_flags.size() == 0);
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_stall <= (rsp_wait > 1);
      end else if (random_stall_on && rsp_valid && !rsp_stall) begin
         w = $urandom_range(0, 8);
         rsp_wait  <= w;
         rsp_stall <= (w > 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      flags_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_flags.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            want = expected_flags.pop_front();
            if (rsp_overlap !== want.overlap ||
                rsp_first_vertex_inside !== want.enclosed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: overlap exp %b got %b, inside exp %b got %b",
                           want.overlap, rsp_overlap, want.enclosed,
                           rsp_first_vertex_inside);
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      coord_type z[12];
      mismatches      = 0;
      hold_cycles     = 0;
      random_stall_on = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      foreach (z[i]) z[i] = 0;
      {req_tri1_ax, req_tri1_ay, req_tri1_bx, req_tri1_by} = '0;
      {req_tri1_cx, req_tri1_cy, req_tri2_ax, req_tri2_ay} = '0;
      {req_tri2_bx, req_tri2_by, req_tri2_cx, req_tri2_cy} = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      drain_pause();
      random_stall_on = 1'b1;
      test_random(200);
      drain_pause();
      test_backpressure();
      test_random(200);
      stop_sending();
      wait (expected_flags.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- triangle_overlap_test_2d.f -----
+incdir+sv
sv/tol_pkg.sv
sv/tol_orient.sv
sv/tol_decide.sv
sv/triangle_overlap_test_2d.sv
tb/sv/tb_triangle_overlap_test_2d.sv
